>>> rtl/rct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table package
// Shared sizes, codes, payload structs and controller command types.
// ----------------------------------------------------------------------------
package rct_pkg;

    // Table geometry.
    localparam int ENTRIES    = 16;
    localparam int ID_BITS    = 8;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Fixed field widths of the request and response.
    localparam int ACTION_W   = 2;
    localparam int SID_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int REFCNT_W   = 16;

    // Largest count a slot can hold.
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ACQUIRE = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_MARK    = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETING  = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [SID_W-1:0]   entry_id;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [REFCNT_W-1:0] ref_count;
        logic                entry_usable;
    } rsp_t;

    // Controller states.
    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
    } cmd_t;

endpackage : rct_pkg
`default_nettype wire

>>> rtl/rct_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table controller
// Sequences each request through capture and apply, and owns the response
// valid flag.
// ----------------------------------------------------------------------------
module rct_ctrl
    import rct_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    output logic        rsp_valid,
    input  wire logic   rsp_ready,
    output cmd_t        cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // State and response valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // The update waits until the response register is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A response is held until its transaction completes.
    always_comb
    begin
        if (cmd.apply)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    // Capture and apply never fall in the same cycle.
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.apply))
        else $error("capture and apply issued together");

    // Once a request is taken, no other is taken in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous one in progress");

    // A response appears only after an apply command.
    a_rsp_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd.apply))
        else $error("response valid without apply");
`endif

endmodule : rct_ctrl
`default_nettype wire

>>> rtl/rct_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table datapath
// Holds the slot table, compares the id against every live slot on capture
// and performs the table update and response on apply.
// ----------------------------------------------------------------------------
module rct_dpath
    import rct_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire req_t   req,
    output rsp_t        rsp
);

    // Slot table.
    logic [ID_BITS-1:0]    slot_id_reg     [ENTRIES];
    logic [COUNT_BITS-1:0] slot_count_reg  [ENTRIES];
    logic [ENTRIES-1:0]    slot_live_reg;
    logic [ENTRIES-1:0]    slot_live_next;
    logic [ENTRIES-1:0]    slot_doomed_reg;
    logic [ENTRIES-1:0]    slot_doomed_next;

    // Captured request and lookup results.
    action_t               act_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic                  free_any_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    // Lookup signals.
    logic [ID_BITS-1:0]    req_id;
    logic [ENTRIES-1:0]    hit_vec;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      free_idx;

    // Apply signals.
    logic [IDX_W-1:0]      sel_idx;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  cur_doomed;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_count;

    assign req_id = ID_BITS'(req.entry_id);

    // Parallel compare against the live slots and lowest free slot search.
    always_comb
    begin
        hit_vec  = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i] = slot_live_reg[i] && (slot_id_reg[i] == req_id);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!slot_live_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // Request and lookup registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg      <= req.action;
            id_reg       <= req_id;
            hit_reg      <= |hit_vec;
            hit_idx_reg  <= hit_idx;
            free_any_reg <= ~&slot_live_reg;
            free_idx_reg <= free_idx;
        end
    end

    assign sel_idx    = hit_reg ? hit_idx_reg : free_idx_reg;
    assign cur_count  = slot_count_reg[sel_idx];
    assign cur_doomed = slot_doomed_reg[sel_idx];

    // Table update and response for the captured request.
    always_comb
    begin
        slot_live_next   = slot_live_reg;
        slot_doomed_next = slot_doomed_reg;
        wr_en            = 1'b0;
        wr_count         = cur_count;
        rsp_next         = rsp_reg;
        if (cmd.apply)
        begin
            rsp_next.status       = ST_OK;
            rsp_next.ref_count    = '0;
            rsp_next.entry_usable = 1'b0;
            case (act_reg)
                ACT_ACQUIRE:
                begin
                    if (!hit_reg && !free_any_reg)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else if (!hit_reg)
                    begin
                        // Claim a fresh slot; its count goes from zero to one.
                        slot_live_next[sel_idx]   = 1'b1;
                        slot_doomed_next[sel_idx] = 1'b0;
                        wr_en                     = 1'b1;
                        wr_count                  = COUNT_BITS'(1);
                        rsp_next.ref_count        = REFCNT_W'(wr_count);
                        rsp_next.entry_usable     = 1'b1;
                    end
                    else if (cur_doomed)
                    begin
                        rsp_next.status    = ST_DELETING;
                        rsp_next.ref_count = REFCNT_W'(cur_count);
                    end
                    else if (cur_count == COUNT_MAX)
                    begin
                        rsp_next.status       = ST_SATURATED;
                        rsp_next.ref_count    = REFCNT_W'(cur_count);
                        rsp_next.entry_usable = 1'b1;
                    end
                    else
                    begin
                        wr_en                 = 1'b1;
                        wr_count              = cur_count + COUNT_BITS'(1);
                        rsp_next.ref_count    = REFCNT_W'(wr_count);
                        rsp_next.entry_usable = 1'b1;
                    end
                end
                ACT_RELEASE:
                begin
                    if (!hit_reg)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else if (cur_count == '0)
                    begin
                        rsp_next.entry_usable = !cur_doomed;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_count = cur_count - COUNT_BITS'(1);
                        if ((wr_count == '0) && cur_doomed)
                        begin
                            // Last reference to a marked entry frees it.
                            slot_live_next[sel_idx]   = 1'b0;
                            slot_doomed_next[sel_idx] = 1'b0;
                        end
                        else
                        begin
                            rsp_next.ref_count    = REFCNT_W'(wr_count);
                            rsp_next.entry_usable = !cur_doomed;
                        end
                    end
                end
                ACT_MARK:
                begin
                    if (!hit_reg)
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                    else if (cur_count == '0)
                    begin
                        // Unreferenced entries are freed immediately.
                        slot_live_next[sel_idx]   = 1'b0;
                        slot_doomed_next[sel_idx] = 1'b0;
                    end
                    else
                    begin
                        slot_doomed_next[sel_idx] = 1'b1;
                        rsp_next.ref_count        = REFCNT_W'(cur_count);
                    end
                end
                ACT_QUERY:
                begin
                    if (hit_reg)
                    begin
                        rsp_next.ref_count    = REFCNT_W'(cur_count);
                        rsp_next.entry_usable = !cur_doomed;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end
    end

    // Slot flags are cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_live_reg   <= '0;
            slot_doomed_reg <= '0;
        end
        else
        begin
            slot_live_reg   <= slot_live_next;
            slot_doomed_reg <= slot_doomed_next;
        end
    end

    // Slot ids, counts and the response payload.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_id_reg[sel_idx]    <= id_reg;
            slot_count_reg[sel_idx] <= wr_count;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

`ifndef SYNTHESIS
    // A slot can be marked only while it is live.
    a_doomed_is_live: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_doomed_reg & ~slot_live_reg) == '0)
        else $error("marked slot is not live");

    // Live ids are unique, so at most one slot matches.
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("id matches more than one live slot");

    // Slot ids and counts are written only in the apply cycle.
    a_write_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cmd.apply)
        else $error("slot written outside apply");
`endif

endmodule : rct_dpath
`default_nettype wire

>>> rtl/reference_count_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reference count table top level
// Table of reference-counted entries with deferred delete.
// ----------------------------------------------------------------------------
// Each request passes through capture and apply: in the cycle it is accepted
// its id is compared against all live slots, the lowest free slot is found
// and the results are registered; in the apply state the slot is updated and
// the response register is loaded. A new request is accepted only once the
// current one has been applied, so requests are not overlapped. The apply
// waits while the response register still holds a result that has not been
// taken. Slot flags are cleared directly by reset; there is no clearing
// pass.
module reference_count_table_top
    import rct_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire req_t   req,
    output logic        rsp_valid,
    input  wire logic   rsp_ready,
    output rsp_t        rsp
);

    cmd_t cmd;

    // Request sequencing.
    rct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    // Slot table and response.
    rct_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule : reference_count_table_top
`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Reference count table testbench
// Drives acquire, release, mark and query requests into the table and checks
// every response against a behavioral copy of the table kept in the bench.
// Directed tests cover lookups of unknown ids, deferred delete, a long count
// climb and a full table. Random traffic over a small pool of hot ids
// follows, with random idle bursts on both channels and a quiet tail at the
// end.
// ----------------------------------------------------------------------------
module testbench
    import rct_pkg::*;
();

    localparam int POOL_SIZE = 24;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_ready;
    req_t   req = '0;
    logic   rsp_valid;
    logic   rsp_ready = 1'b0;
    rsp_t   rsp;

    // Bench copy of the slot table.
    logic [ID_BITS-1:0]    tbl_id     [ENTRIES];
    logic [COUNT_BITS-1:0] tbl_count  [ENTRIES];
    logic                  tbl_live   [ENTRIES];
    logic                  tbl_doomed [ENTRIES];

    rsp_t               pending_rsps[$];
    logic [SID_W-1:0]   id_pool [POOL_SIZE];
    bit                 idle_en = 1'b1;
    int                 stall_left = 0;
    int                 errors = 0;

    reference_count_table_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the bench table and return the response it yields.
    function automatic rsp_t apply_table_request(input req_t r);
        logic [ID_BITS-1:0] key;
        int                 hit;
        int                 i;
        rsp_t               res;
        key = r.entry_id[ID_BITS-1:0];
        hit = -1;
        res.status = ST_OK;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_live[i] && tbl_id[i] == key)
                hit = i;
        end
        case (r.action)
            ACT_ACQUIRE:
            begin
                // A new id claims the lowest slot that is not live.
                if (hit < 0)
                begin
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        if (hit < 0 && !tbl_live[i])
                        begin
                            tbl_id[i] = key;
                            tbl_count[i] = '0;
                            tbl_live[i] = 1'b1;
                            tbl_doomed[i] = 1'b0;
                            hit = i;
                        end
                    end
                end
                if (hit < 0)
                    res.status = ST_FULL;
                else if (tbl_doomed[hit])
                    res.status = ST_DELETING;
                else if (tbl_count[hit] == COUNT_MAX)
                    res.status = ST_SATURATED;
                else
                    tbl_count[hit] = tbl_count[hit] + 1'b1;
            end
            ACT_RELEASE:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else if (tbl_count[hit] != '0)
                begin
                    tbl_count[hit] = tbl_count[hit] - 1'b1;
                    // The last release of a doomed entry frees its slot.
                    if (tbl_count[hit] == '0 && tbl_doomed[hit])
                    begin
                        tbl_live[hit] = 1'b0;
                        tbl_doomed[hit] = 1'b0;
                        hit = -1;
                    end
                end
            end
            ACT_MARK:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    tbl_doomed[hit] = 1'b1;
                    // An unreferenced entry goes away at once.
                    if (tbl_count[hit] == '0)
                    begin
                        tbl_live[hit] = 1'b0;
                        tbl_doomed[hit] = 1'b0;
                        hit = -1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (hit >= 0)
        begin
            res.ref_count = tbl_count[hit];
            res.entry_usable = !tbl_doomed[hit];
        end
        else
        begin
            res.ref_count = '0;
            res.entry_usable = 1'b0;
        end
        return res;
    endfunction

    // Send one request transaction, with an optional idle burst before it.
    task automatic send_request(input action_t act, input logic [SID_W-1:0] sid);
        req_t r;
        r.action = act;
        r.entry_id = sid;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_rsps.push_back(apply_table_request(r));
    endtask

    // Response side back-pressure in random bursts.
    always @(posedge clk)
    begin
        if (idle_en && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Compare every response transaction with the oldest expected one.
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsps.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
            end
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.ref_count !== want.ref_count)
                begin
                    $error("ref_count: expected %0d, actual %0d",
                           want.ref_count, rsp.ref_count);
                    errors++;
                end
                if (rsp.entry_usable !== want.entry_usable)
                begin
                    $error("entry_usable: expected %0d, actual %0d",
                           want.entry_usable, rsp.entry_usable);
                    errors++;
                end
            end
        end
    end

    // Unknown ids, the basic count walk and marking an unreferenced entry.
    task automatic test_basic_lookups();
        send_request(ACT_QUERY, 8'h00);
        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_MARK, 8'h80);
        send_request(ACT_ACQUIRE, 8'h00);
        send_request(ACT_ACQUIRE, 8'h00);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_QUERY, 8'h00);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_RELEASE, 8'h00);
        send_request(ACT_MARK, 8'h00);
        send_request(ACT_QUERY, 8'h00);
    endtask

    // A marked entry refuses acquires and goes away on its last release.
    task automatic test_deferred_delete();
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_MARK, 8'hFF);
        send_request(ACT_ACQUIRE, 8'hFF);
        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_RELEASE, 8'hFF);
        send_request(ACT_QUERY, 8'hFF);
    endtask

    // Drive one count well up back to back, then leave the entry doomed but held.
    task automatic test_count_climb();
        repeat (32)
            send_request(ACT_ACQUIRE, 8'hA5);
        send_request(ACT_MARK, 8'hA5);
        send_request(ACT_RELEASE, 8'hA5);
    endtask

    // Acquire ENTRIES+1 distinct ids so the table fills and the last acquires are
    // refused, then mark and release each one so its slot is free for the traffic after.
    task automatic test_table_full();
        int i;
        for (i = 0; i <= ENTRIES; i++)
            send_request(ACT_ACQUIRE, SID_W'(8'h30 + i));
        for (i = 0; i <= ENTRIES; i++)
            send_request(ACT_MARK, SID_W'(8'h30 + i));
        for (i = 0; i <= ENTRIES; i++)
            send_request(ACT_RELEASE, SID_W'(8'h30 + i));
    endtask

    // Weighted random traffic, mostly on a pool of hot ids.
    task automatic test_random_traffic(input int n_items);
        int               k;
        int               roll;
        action_t          act;
        logic [SID_W-1:0] sid;
        for (k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                act = ACT_ACQUIRE;
            else if (roll < 75)
                act = ACT_RELEASE;
            else if (roll < 85)
                act = ACT_MARK;
            else
                act = ACT_QUERY;
            if ($urandom_range(0, 4) != 0)
                sid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                sid = SID_W'($urandom);
            send_request(act, sid);
        end
    endtask

    // Main sequence.
    initial
    begin : main
        int i;
        for (i = 0; i < ENTRIES; i++)
        begin
            tbl_live[i] = 1'b0;
            tbl_doomed[i] = 1'b0;
        end
        for (i = 0; i < POOL_SIZE; i++)
            id_pool[i] = SID_W'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_lookups();
        test_deferred_delete();
        idle_en = 1'b0;
        test_count_climb();
        idle_en = 1'b1;
        test_table_full();
        test_random_traffic(1100);
        idle_en = 1'b0;
        test_random_traffic(400);
        req_valid <= 1'b0;

        // Drain outstanding responses, then leave the bus quiet before finishing.
        while (pending_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #40_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> files.f
rtl/rct_pkg.sv
rtl/rct_ctrl.sv
rtl/rct_dpath.sv
rtl/reference_count_table_top.sv
test/testbench.sv
